FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

  localparam int unsigned KwCount = 40;
  localparam int unsigned LongestKeywordDefault = 9;
  localparam int unsigned ChW = 7;
  localparam int unsigned KindW = 5;
  localparam int unsigned KwIdxW = 6;
  localparam int unsigned LenW = 4;
  localparam int unsigned LenMax = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [ChW-1:0] CaseBit = 7'h20;
  localparam logic [KwCount-1:0] KwExtMask = 40'h80_E000_0001;

  localparam logic [CfgIdxW-1:0] CfgFinalParse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExtSyntax  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgExtKw      = 2'd2;

  typedef enum logic [KindW-1:0] {
    TkEnd = 5'd0, TkId = 5'd1, TkKeyword = 5'd2, TkInt = 5'd3, TkReal = 5'd4,
    TkString = 5'd5, TkChar = 5'd6, TkComment = 5'd7, TkDotDot = 5'd8,
    TkLParen = 5'd9, TkSemi = 5'd10, TkComma = 5'd11, TkColon = 5'd12,
    TkStar = 5'd13, TkPlus = 5'd14, TkSlash = 5'd15, TkMinus = 5'd16,
    TkRParen = 5'd17, TkLBrack = 5'd18, TkRBrack = 5'd19, TkEq = 5'd20,
    TkLt = 5'd21, TkLe = 5'd22, TkNe = 5'd23, TkGt = 5'd24, TkGe = 5'd25,
    TkCaret = 5'd26, TkQuest = 5'd27, TkDot = 5'd28, TkIllegal = 5'd29
  } token_kind_e;

  typedef enum logic [4:0] {
    PhIdle, PhIdent, PhInt, PhIntDot, PhFrac, PhExp, PhExpSign, PhExpDig,
    PhStr, PhStrQuote, PhDot, PhComment, PhLt, PhGt, PhHex, PhHash, PhIll
  } scan_phase_e;

  // One result beat
  typedef struct packed {
    logic [KwIdxW-1:0] kw;
    logic [KindW-1:0]  kind;
  } token_t;

  // What one character does to the scanner
  typedef struct packed {
    logic   ident_start;   // restart the keyword cells
    logic   ident_adv;     // advance the keyword cells
    logic   ident_finish;  // identifier ends: ask the cells for a match
    logic   n_tok;         // this character yields at least one result
    logic   two;
    token_t tok0;
    token_t tok1;
  } scan_ctl_t;

  // Keyword letters, keyword k at position p, 0 past its end
  function automatic logic [ChW-1:0] kw_char(input int unsigned k, input int unsigned p);
    string s;
    logic [7:0] b;
    s = "";
    b = '0;
    case (k)
      0: s = "absolute"; 1: s = "and"; 2: s = "array"; 3: s = "begin";
      4: s = "case"; 5: s = "const"; 6: s = "div"; 7: s = "do";
      8: s = "downto"; 9: s = "else"; 10: s = "end"; 11: s = "file";
      12: s = "for"; 13: s = "function"; 14: s = "goto"; 15: s = "if";
      16: s = "in"; 17: s = "label"; 18: s = "mod"; 19: s = "nil";
      20: s = "not"; 21: s = "of"; 22: s = "or"; 23: s = "packed";
      24: s = "procedure"; 25: s = "program"; 26: s = "record"; 27: s = "repeat";
      28: s = "set"; 29: s = "shl"; 30: s = "shr"; 31: s = "string";
      32: s = "then"; 33: s = "to"; 34: s = "type"; 35: s = "until";
      36: s = "var"; 37: s = "while"; 38: s = "with"; 39: s = "xor";
      default: s = "";
    endcase
    if (p < s.len()) b = s[p];
    return b[ChW-1:0];
  endfunction

  function automatic int unsigned kw_len(input int unsigned k);
    int unsigned n;
    n = 0;
    for (int unsigned p = 0; p < 9; p++) begin
      if (kw_char(k, p) != '0) n = p + 1;
    end
    return n;
  endfunction

  function automatic logic is_alpha(input logic [ChW-1:0] c);
    return ((c | CaseBit) >= 7'h61) && ((c | CaseBit) <= 7'h7a);
  endfunction

  function automatic logic is_digit(input logic [ChW-1:0] c);
    return (c >= 7'h30) && (c <= 7'h39);
  endfunction

endpackage

FILE: rtl/pascal_token_scanner_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tdata[6:0] ch
// m_axis    out        tdata[4:0] kind, [10:5] keyword index; tlast last of step
// cfg       in         cfg_index_i, cfg_data_i
// One character per cycle while the queue has room; the keyword cells narrow on each letter.
// A character causing two tokens is taken once both queue entries are free,
// counting an entry that leaves in the same cycle.
// Results go through a two-entry output queue, so stalls on m_axis block input
// only when it cannot hold this character's results.
// Reset is asynchronous, active low; scanner starts between tokens.
module pascal_token_scanner_top import pts_pkg::*; #(
  parameter int unsigned LongestKeyword = LongestKeywordDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [4:0] token_kind, [10:5] keyword_index
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic        cfg_data_i
);
  scan_phase_e ph_q, ph_d;
  logic [LenW-1:0] len_q, len_d;
  logic [1:0] cnt_q, cnt_d;
  logic dq_q, dq_d, real_q, real_d;
  logic [ChW-1:0] rep_q, rep_d;
  logic final_q, exts_q, extk_q;

  logic [ChW-1:0] c;
  logic acc, kw_found;
  logic [KwIdxW-1:0] kw_idx;
  scan_ctl_t ctl;

  // output queue: two entries of {token, last}
  token_t q_tok [2];
  logic   q_last [2];
  logic [1:0] q_cnt_q;
  logic   q_rd_q;

  assign c = s_axis_tdata[ChW-1:0];

  // Start-of-token decode: returns emitted kind (valid flag) and next phase
  function automatic void start_tok(input logic [ChW-1:0] ch, input logic exts,
                                    output logic em, output token_kind_e k,
                                    output scan_phase_e np);
    em = 1'b0; k = TkEnd; np = PhIdle;
    if (ch == 7'h20 || ch == 7'h09) np = PhIdle;
    else if (is_alpha(ch) || ch == 7'h5f) np = PhIdent;
    else if (is_digit(ch)) np = PhInt;
    else begin
      case (ch)
        7'h00: begin em = 1'b1; k = TkEnd; end
        7'h22, 7'h27: np = PhStr;
        7'h2e: np = PhDot;
        7'h7b: np = PhComment;
        7'h3c: np = PhLt;
        7'h3e: np = PhGt;
        7'h28: begin em = 1'b1; k = TkLParen; end
        7'h3b: begin em = 1'b1; k = TkSemi; end
        7'h2c: begin em = 1'b1; k = TkComma; end
        7'h3a: begin em = 1'b1; k = TkColon; end
        7'h3d: begin em = 1'b1; k = TkEq; end
        7'h2a: begin em = 1'b1; k = TkStar; end
        7'h2b: begin em = 1'b1; k = TkPlus; end
        7'h2f: begin em = 1'b1; k = TkSlash; end
        7'h2d: begin em = 1'b1; k = TkMinus; end
        7'h29: begin em = 1'b1; k = TkRParen; end
        7'h5b: begin em = 1'b1; k = TkLBrack; end
        7'h5d: begin em = 1'b1; k = TkRBrack; end
        7'h3f: begin em = 1'b1; k = TkQuest; end
        7'h5e: begin em = 1'b1; k = TkCaret; end
        default: begin
          if (exts && ch == 7'h24) np = PhHex;
          else if (exts && ch == 7'h23) np = PhHash;
          else np = PhIll;
        end
      endcase
    end
  endfunction

  // Next phase and results for one character
  always_comb begin
    logic rescan, em0, em1, sem, isq, ident_ch, xd;
    token_kind_e k0, k1, sk;
    scan_phase_e snp;
    rescan = 1'b0; em0 = 1'b0; em1 = 1'b0; k0 = TkEnd; k1 = TkEnd;
    sem = 1'b0; sk = TkEnd; snp = PhIdle;
    ph_d = PhIdle; len_d = len_q; cnt_d = cnt_q; dq_d = dq_q;
    real_d = real_q; rep_d = rep_q;
    ctl = '0;
    isq = dq_q ? (c == 7'h22) : (c == 7'h27);
    ident_ch = is_alpha(c) || is_digit(c) || c == 7'h5f;
    xd = is_digit(c) || (((c | CaseBit) >= 7'h61) && ((c | CaseBit) <= 7'h66));
    case (ph_q)
      PhIdle: rescan = 1'b1;
      PhIdent: begin
        if (ident_ch) begin
          ctl.ident_adv = 1'b1; ph_d = PhIdent;
          if (len_q != LenW'(LenMax)) len_d = len_q + 1'b1;
        end else if (c == '0) begin em0 = 1'b1; k0 = TkEnd; end
        else begin
          em0 = 1'b1; rescan = 1'b1; ctl.ident_finish = 1'b1;
          k0 = (kw_found && 32'(len_q) <= LongestKeyword) ? TkKeyword : TkId;
        end
      end
      PhInt, PhIntDot, PhFrac: begin
        if (ph_q == PhIntDot && c == 7'h2e) begin
          em0 = 1'b1; k0 = TkInt; em1 = 1'b1; k1 = TkDotDot;
        end else if (ph_q != PhIntDot && is_digit(c)) ph_d = ph_q;
        else if (ph_q == PhInt && c == 7'h2e) ph_d = PhIntDot;
        else if (ph_q == PhIntDot && is_digit(c)) begin real_d = 1'b1; ph_d = PhFrac; end
        else if ((c | CaseBit) == 7'h65) begin real_d = 1'b1; ph_d = PhExp; end
        else if (c == '0) begin em0 = 1'b1; k0 = TkEnd; end
        else begin
          em0 = 1'b1; rescan = 1'b1;
          k0 = (real_q || ph_q == PhIntDot) ? TkReal : TkInt;
        end
      end
      PhExp, PhExpSign, PhExpDig: begin
        if (ph_q == PhExp && (c == 7'h2b || c == 7'h2d)) ph_d = PhExpSign;
        else if (is_digit(c)) ph_d = PhExpDig;
        else if (c == '0) begin em0 = 1'b1; k0 = TkEnd; end
        else begin em0 = 1'b1; k0 = TkReal; rescan = 1'b1; end
      end
      PhStr, PhStrQuote: begin
        if (c == '0) begin
          em0 = 1'b1;
          if (final_q) begin k0 = TkIllegal; em1 = 1'b1; k1 = TkEnd; end
          else k0 = TkEnd;
        end else if (isq && ph_q == PhStr) ph_d = PhStrQuote;
        else if (ph_q == PhStr || isq) begin
          ph_d = PhStr;
          if (cnt_q != 2'd2) cnt_d = cnt_q + 1'b1;
        end else begin
          em0 = 1'b1; rescan = 1'b1;
          k0 = (!dq_q && cnt_q == 2'd1) ? TkChar : TkString;
        end
      end
      PhDot: begin
        if (c == 7'h2e) begin em0 = 1'b1; k0 = TkDotDot; end
        else if (is_digit(c)) begin real_d = 1'b1; ph_d = PhFrac; end
        else begin em0 = 1'b1; k0 = TkDot; rescan = 1'b1; end
      end
      PhComment: begin
        if (c == 7'h7d) begin em0 = 1'b1; k0 = TkComment; end
        else if (c == '0) begin em0 = 1'b1; k0 = TkEnd; end
        else ph_d = PhComment;
      end
      PhLt: begin
        em0 = 1'b1;
        if (c == 7'h3d) k0 = TkLe;
        else if (c == 7'h3e) k0 = TkNe;
        else if (c == '0) k0 = TkEnd;
        else begin k0 = TkLt; rescan = 1'b1; end
      end
      PhGt: begin
        em0 = 1'b1;
        if (c == 7'h3d) k0 = TkGe;
        else if (c == '0) k0 = TkEnd;
        else begin k0 = TkGt; rescan = 1'b1; end
      end
      PhHex, PhHash: begin
        if (ph_q == PhHex ? xd : is_digit(c)) ph_d = ph_q;
        else if (c == '0) begin em0 = 1'b1; k0 = TkEnd; end
        else begin em0 = 1'b1; rescan = 1'b1; k0 = (ph_q == PhHex) ? TkInt : TkChar; end
      end
      PhIll: begin
        if (c == rep_q) ph_d = PhIll;
        else begin em0 = 1'b1; k0 = TkIllegal; rescan = 1'b1; end
      end
      default: rescan = 1'b1;
    endcase
    if (rescan) begin
      start_tok(c, exts_q, sem, sk, snp);
      ph_d = snp;
      case (snp)
        PhIdent: begin ctl.ident_start = 1'b1; len_d = LenW'(1); end
        PhInt: real_d = 1'b0;
        PhStr: begin dq_d = (c == 7'h22); cnt_d = '0; end
        PhIll: rep_d = c;
        default: ;
      endcase
      if (sem) begin
        if (em0) begin em1 = 1'b1; k1 = sk; end
        else begin em0 = 1'b1; k0 = sk; end
      end
    end
    ctl.n_tok = em0;
    ctl.two = em1;
    ctl.tok0.kind = k0;
    ctl.tok0.kw = (k0 == TkKeyword) ? kw_idx : '0;
    ctl.tok1.kind = k1;
    ctl.tok1.kw = '0;
  end

  pts_kw_chain u_chain (
    .clk_i, .rst_ni,
    .start_i(acc && ctl.ident_start),
    .adv_i(acc && ctl.ident_adv),
    .pos_i(ctl.ident_start ? LenW'(0) : len_q),
    .ch_i(c), .len_i(len_q), .ext_kw_i(extk_q),
    .found_o(kw_found), .idx_o(kw_idx));

  // Accept when the queue has room for this character's results
  logic pop;
  logic [1:0] need, room;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign need = {ctl.two, ctl.n_tok && !ctl.two};
  assign room = 2'd2 - q_cnt_q + {1'b0, pop};
  assign s_axis_tready = (need <= room);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; len_q <= '0; cnt_q <= '0; dq_q <= 1'b0;
      real_q <= 1'b0; rep_q <= '0;
    end else if (acc) begin
      ph_q <= ph_d; len_q <= len_d; cnt_q <= cnt_d; dq_q <= dq_d;
      real_q <= real_d; rep_q <= rep_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_q <= 1'b0; exts_q <= 1'b0; extk_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFinalParse: final_q <= cfg_data_i;
        CfgExtSyntax:  exts_q  <= cfg_data_i;
        CfgExtKw:      extk_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output queue, circular over two entries
  logic [1:0] q_cnt_d;
  logic q_wr;
  assign q_wr = q_rd_q ^ q_cnt_q[0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0; q_rd_q <= 1'b0;
    end else begin
      q_cnt_q <= q_cnt_d;
      if (pop) q_rd_q <= ~q_rd_q;
    end
  end
  always_comb q_cnt_d = q_cnt_q - {1'b0, pop} + (acc ? need : 2'd0);

  always_ff @(posedge clk_i) begin
    if (acc && ctl.n_tok) begin
      q_tok[q_wr]  <= ctl.tok0;
      q_last[q_wr] <= !ctl.two;
      if (ctl.two) begin
        q_tok[~q_wr]  <= ctl.tok1;
        q_last[~q_wr] <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = (q_cnt_q != 2'd0);
  assign m_axis_tdata  = {5'd0, q_tok[q_rd_q].kw, q_tok[q_rd_q].kind};
  assign m_axis_tlast  = q_last[q_rd_q];

`ifndef NO_ASSERTIONS
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= 2'd2) else $error("output queue overflow");
  a_kw_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:0] != TkKeyword |-> m_axis_tdata[10:5] == 6'd0)
    else $error("keyword index on non-keyword token");
  a_two_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && ctl.two |=> m_axis_tvalid) else $error("two-token step lost");
`endif
endmodule

FILE: rtl/pts_kw_cell.sv
`timescale 1ns / 1ps
// One keyword cell: holds whether its keyword still matches the identifier
module pts_kw_cell import pts_pkg::*; #(
  parameter int unsigned KwIdx = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           adv_i,
  input  logic [LenW-1:0] pos_i,
  input  logic [ChW-1:0] ch_i,
  input  logic [LenW-1:0] len_i,
  input  logic           ext_kw_i,
  input  logic           found_i,   // match from a lower-numbered cell
  output logic           found_o,
  output logic [KwIdxW-1:0] idx_o
);
  localparam int unsigned Len = kw_len(KwIdx);
  localparam logic Ext = KwExtMask[KwIdx];

  logic alive_q, alive_d, hit;
  logic [ChW-1:0] want;

  always_comb begin
    want = '0;
    for (int unsigned p = 0; p < Len; p++) begin
      if (pos_i == LenW'(p)) want = kw_char(KwIdx, p);
    end
  end

  // narrow on each identifier character
  always_comb begin
    alive_d = alive_q;
    if (start_i) alive_d = (32'(pos_i) < Len) && ((ch_i | CaseBit) == want);
    else if (adv_i) alive_d = alive_q && (32'(pos_i) < Len) && ((ch_i | CaseBit) == want);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) alive_q <= 1'b1;
    else alive_q <= alive_d;
  end

  assign hit     = alive_q && (len_i == LenW'(Len)) && (ext_kw_i || !Ext);
  assign found_o = found_i || hit;
  assign idx_o   = (!found_i && hit) ? KwIdxW'(KwIdx) : '0;
endmodule

FILE: rtl/pts_kw_chain.sv
`timescale 1ns / 1ps
// Row of keyword cells, first match in alphabetical order wins
module pts_kw_chain import pts_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           adv_i,
  input  logic [LenW-1:0] pos_i,
  input  logic [ChW-1:0] ch_i,
  input  logic [LenW-1:0] len_i,
  input  logic           ext_kw_i,
  output logic           found_o,
  output logic [KwIdxW-1:0] idx_o
);
  logic [KwCount:0] chain;
  logic [KwIdxW-1:0] idx [KwCount];

  assign chain[0] = 1'b0;
  for (genvar k = 0; k < KwCount; k++) begin : g_cell
    pts_kw_cell #(.KwIdx(k)) u_cell (
      .clk_i, .rst_ni, .start_i, .adv_i, .pos_i, .ch_i, .len_i, .ext_kw_i,
      .found_i(chain[k]), .found_o(chain[k+1]), .idx_o(idx[k]));
  end

  always_comb begin
    idx_o = '0;
    for (int k = 0; k < KwCount; k++) idx_o = idx_o | idx[k];
  end
  assign found_o = chain[KwCount];
endmodule
